// ----- rtl/block_cipher_padding_engine_unit_defines.svh -----
// Assertion macros shared by the padding engine modules.
// Define NO_ASSERTIONS to compile them out.
`ifndef BLOCK_CIPHER_PADDING_ENGINE_UNIT_DEFINES_SVH
`define BLOCK_CIPHER_PADDING_ENGINE_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// property holds at every clock edge outside reset
`define BCPE_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("bcpe assertion failed");
// consequent holds in the cycle after the antecedent
`define BCPE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bcpe assertion failed");
`else
`define BCPE_ASSERT(lbl, clk, rst, prop)
`define BCPE_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ----- rtl/bcpe_pkg.sv -----
`timescale 1ns / 1ps

package bcpe_pkg;

   // cipher block size in bytes
   localparam int BLOCK_BYTES = 16;
   // count 0..BLOCK_BYTES, byte index 0..BLOCK_BYTES-1
   localparam int CNT_W = $clog2(BLOCK_BYTES + 1);
   localparam int IDX_W = $clog2(BLOCK_BYTES);
   localparam int TOT_W = CNT_W + 1;

   // supplied random filler bytes
   localparam int RAND_BYTES = 15;

   // command queue between front and back
   localparam int FIFO_DEPTH = 2;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

   // pad schemes (code 3 behaves as PKCS7)
   localparam logic [1:0] SCHEME_PKCS7    = 2'd0;
   localparam logic [1:0] SCHEME_ISO10126 = 2'd1;
   localparam logic [1:0] SCHEME_X923     = 2'd2;
   localparam logic [1:0] SCHEME_RESERVED = 2'd3;

   // result status
   localparam logic [1:0] STATUS_OK          = 2'd0;
   localparam logic [1:0] STATUS_BAD_LENGTH  = 2'd1;
   localparam logic [1:0] STATUS_BAD_CONTENT = 2'd2;

   // register indexes
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 2;
   localparam logic [CSR_IDX_W-1:0] REG_PAD_SCHEME      = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_STRIP_DIRECTION = 1'd1;

   typedef struct packed {
      logic [1:0] pad_scheme;
      logic       strip_direction;
   } cfg_type;

   // one command: optional lead byte, body bytes, optional status word
   typedef struct packed {
      logic                        lead_valid;
      logic [7:0]                  lead_byte;
      logic [CNT_W-1:0]            body_count;
      logic                        status_only;
      logic [1:0]                  status;
      logic                        msg_end;
      logic [BLOCK_BYTES-1:0][7:0] body;
   } cmd_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       has_byte;
      logic       run_end;
      logic       message_end;
      logic [1:0] status;
   } rsp_type;

endpackage

// ----- rtl/block_cipher_padding_engine_unit.sv -----
`timescale 1ns / 1ps
// A byte's first result passes through the command queue and then the output register.
// Throughput: one byte per cycle while no pad burst runs and the output is not stalled;
// a final byte adds a burst of pad bytes (pad) or of kept bytes or a status word (strip),
// sent by the back-end sequencer at one word per cycle while the output accepts. A 2-entry
// command queue lets the front keep accepting during short bursts.
// Reset (synchronous, active high): config, counters and queue clear; held bytes undefined.

module block_cipher_padding_engine_unit (
   input  logic                                clock,
   input  logic                                reset,
   // req_tdata: [7:0] data_byte, [71:8] fill_random_low, [127:72] fill_random_high
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [127:0]                        req_tdata,
   input  logic                                req_tlast,
   // rsp_tdata: [7:0] out_byte, [9:8] status, [15:10] zero
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [15:0]                         rsp_tdata,
   // rsp_tuser: [0] has_byte, [1] run_end
   output logic [1:0]                          rsp_tuser,
   output logic                                rsp_tlast,
   input  logic                                csr_wr_en,
   input  logic [bcpe_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bcpe_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   bcpe_pkg::cfg_type cfg_ff, cfg_in;
   bcpe_pkg::cmd_type front_cmd, head_cmd;
   bcpe_pkg::rsp_type rsp_word;
   logic              accept, push, full, pop, head_valid;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            bcpe_pkg::REG_PAD_SCHEME:      cfg_in.pad_scheme      = csr_wdata[1:0];
            bcpe_pkg::REG_STRIP_DIRECTION: cfg_in.strip_direction = csr_wdata[0];
            default:                       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_tready = !full;
   assign accept     = req_tvalid && req_tready;

   bcpe_front u_front (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .accept           (accept),
      .data_byte        (req_tdata[7:0]),
      .final_byte       (req_tlast),
      .fill_random_low  (req_tdata[71:8]),
      .fill_random_high (req_tdata[127:72]),
      .push             (push),
      .cmd              (front_cmd)
   );

   bcpe_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .wr_data  (front_cmd),
      .full     (full),
      .pop      (pop),
      .rd_valid (head_valid),
      .rd_data  (head_cmd)
   );

   bcpe_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head_cmd),
      .pop        (pop),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_word   (rsp_word)
   );

   assign rsp_tdata = {6'd0, rsp_word.status, rsp_word.out_byte};
   assign rsp_tuser = {rsp_word.run_end, rsp_word.has_byte};
   assign rsp_tlast = rsp_word.message_end;

endmodule

// ----- rtl/bcpe_fifo.sv -----
`timescale 1ns / 1ps
`include "block_cipher_padding_engine_unit_defines.svh"

module bcpe_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  bcpe_pkg::cmd_type wr_data,
   output logic              full,
   input  logic              pop,
   output logic              rd_valid,
   output bcpe_pkg::cmd_type rd_data
);

   bcpe_pkg::cmd_type mem_ff [bcpe_pkg::FIFO_DEPTH];
   logic [bcpe_pkg::FIFO_AW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [bcpe_pkg::FIFO_CW-1:0] count_ff, count_in;

   // pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == bcpe_pkg::FIFO_AW'(bcpe_pkg::FIFO_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == bcpe_pkg::FIFO_AW'(bcpe_pkg::FIFO_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   assign full     = count_ff == bcpe_pkg::FIFO_CW'(bcpe_pkg::FIFO_DEPTH);
   assign rd_valid = count_ff != '0;
   assign rd_data  = mem_ff[rd_ptr_ff];

   `BCPE_ASSERT(a_no_overflow, clock, reset, push |-> !full)
   `BCPE_ASSERT_NEXT(a_pop_drains, clock, reset, pop && !push, count_ff == $past(count_ff) - 1'b1)

endmodule

// ----- rtl/bcpe_front.sv -----
`timescale 1ns / 1ps

module bcpe_front (
   input  logic              clock,
   input  logic              reset,
   input  bcpe_pkg::cfg_type cfg,
   input  logic              accept,
   input  logic [7:0]        data_byte,
   input  logic              final_byte,
   input  logic [63:0]       fill_random_low,
   input  logic [55:0]       fill_random_high,
   output logic              push,
   output bcpe_pkg::cmd_type cmd
);

   logic [bcpe_pkg::IDX_W-1:0] pos_ff, pos_in, pos_next;
   logic [bcpe_pkg::CNT_W-1:0] hb_count_ff, hb_count_in, hb_n, pad_len, keep_len;
   logic [7:0]   hb_ff   [bcpe_pkg::BLOCK_BYTES];
   logic [7:0]   new_buf [bcpe_pkg::BLOCK_BYTES];
   logic [7:0]   rnd     [bcpe_pkg::RAND_BYTES];
   logic [119:0] rnd_word;
   logic         hb_full, len_bad, body_bad, is_iso, is_x923;
   logic [1:0]   strip_status;

   always_comb begin
      is_iso  = cfg.pad_scheme == bcpe_pkg::SCHEME_ISO10126;
      is_x923 = cfg.pad_scheme == bcpe_pkg::SCHEME_X923;

      rnd_word = {fill_random_high, fill_random_low};
      for (int k = 0; k < bcpe_pkg::RAND_BYTES; k++) begin
         rnd[k] = rnd_word[8*k +: 8];
      end

      // pad side: position in block and pad length
      pos_next = (pos_ff == bcpe_pkg::IDX_W'(bcpe_pkg::BLOCK_BYTES - 1)) ?
                 '0 : pos_ff + 1'b1;
      pad_len  = bcpe_pkg::CNT_W'(bcpe_pkg::BLOCK_BYTES) - bcpe_pkg::CNT_W'(pos_next);

      // strip side: holdback after taking this byte, oldest first
      hb_full = hb_count_ff == bcpe_pkg::CNT_W'(bcpe_pkg::BLOCK_BYTES);
      hb_n    = hb_full ? bcpe_pkg::CNT_W'(bcpe_pkg::BLOCK_BYTES) : hb_count_ff + 1'b1;
      for (int i = 0; i < bcpe_pkg::BLOCK_BYTES; i++) begin
         if (hb_full) begin
            new_buf[i] = (i == bcpe_pkg::BLOCK_BYTES - 1) ?
                         data_byte : hb_ff[(i + 1) % bcpe_pkg::BLOCK_BYTES];
         end else begin
            new_buf[i] = (bcpe_pkg::CNT_W'(i) == hb_count_ff) ? data_byte : hb_ff[i];
         end
      end

      // pad check: newest byte is the length
      len_bad  = (data_byte == 8'd0) || (data_byte > 8'(bcpe_pkg::BLOCK_BYTES)) ||
                 (data_byte > 8'(hb_n));
      keep_len = hb_n - data_byte[bcpe_pkg::CNT_W-1:0];
      body_bad = 1'b0;
      for (int i = 0; i < bcpe_pkg::BLOCK_BYTES; i++) begin
         if (!is_iso && !is_x923 && (bcpe_pkg::CNT_W'(i) >= keep_len) &&
             (bcpe_pkg::CNT_W'(i) < hb_n) && (new_buf[i] != data_byte)) begin
            body_bad = 1'b1;
         end
         if (is_x923 && (bcpe_pkg::CNT_W'(i) >= keep_len) &&
             (bcpe_pkg::CNT_W'(i) < hb_n - 1'b1) && (new_buf[i] != 8'd0)) begin
            body_bad = 1'b1;
         end
      end
      strip_status = len_bad  ? bcpe_pkg::STATUS_BAD_LENGTH :
                     body_bad ? bcpe_pkg::STATUS_BAD_CONTENT : bcpe_pkg::STATUS_OK;

      // build the command word
      cmd.lead_valid  = 1'b0;
      cmd.lead_byte   = data_byte;
      cmd.body_count  = '0;
      cmd.status_only = 1'b0;
      cmd.status      = bcpe_pkg::STATUS_OK;
      cmd.msg_end     = final_byte;
      pos_in          = pos_ff;
      hb_count_in     = hb_count_ff;
      push            = 1'b0;
      if (!cfg.strip_direction) begin
         cmd.lead_valid = 1'b1;
         cmd.body_count = final_byte ? pad_len : '0;
         for (int j = 0; j < bcpe_pkg::BLOCK_BYTES; j++) begin
            if (bcpe_pkg::CNT_W'(j) == pad_len - 1'b1) begin
               cmd.body[j] = 8'(pad_len);
            end else if (is_iso) begin
               cmd.body[j] = rnd[j % bcpe_pkg::RAND_BYTES];
            end else if (is_x923) begin
               cmd.body[j] = 8'd0;
            end else begin
               cmd.body[j] = 8'(pad_len);
            end
         end
         push = accept;
         if (accept) begin
            pos_in = final_byte ? '0 : pos_next;
         end
      end else begin
         cmd.lead_valid = hb_full;
         cmd.lead_byte  = hb_ff[0];
         for (int j = 0; j < bcpe_pkg::BLOCK_BYTES; j++) begin
            cmd.body[j] = new_buf[j];
         end
         if (final_byte) begin
            cmd.status      = strip_status;
            cmd.body_count  = (strip_status == bcpe_pkg::STATUS_OK) ? keep_len : '0;
            cmd.status_only = (strip_status != bcpe_pkg::STATUS_OK) || (keep_len == '0);
         end
         push = accept && (hb_full || final_byte);
         if (accept) begin
            hb_count_in = final_byte ? '0 : hb_n;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         hb_count_ff <= '0;
      end else begin
         pos_ff      <= pos_in;
         hb_count_ff <= hb_count_in;
      end
   end

   // holdback bytes, valid only below the count
   always_ff @(posedge clock) begin
      if (accept && cfg.strip_direction) begin
         for (int i = 0; i < bcpe_pkg::BLOCK_BYTES; i++) begin
            hb_ff[i] <= new_buf[i];
         end
      end
   end

endmodule

// ----- rtl/bcpe_back.sv -----
`timescale 1ns / 1ps
`include "block_cipher_padding_engine_unit_defines.svh"

module bcpe_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  bcpe_pkg::cmd_type head,
   output logic              pop,
   input  logic              rsp_tready,
   output logic              rsp_tvalid,
   output bcpe_pkg::rsp_type rsp_word
);

   logic [bcpe_pkg::CNT_W-1:0] idx_ff, idx_in, body_idx;
   logic [bcpe_pkg::TOT_W-1:0] last_idx;
   logic              is_lead, in_body, is_last, advance;
   logic              rsp_valid_ff, rsp_valid_in;
   bcpe_pkg::rsp_type item, rsp_ff, rsp_in;

   // sequence: lead byte, body bytes, then the status word
   always_comb begin
      is_lead  = head.lead_valid && (idx_ff == '0);
      body_idx = idx_ff - bcpe_pkg::CNT_W'(head.lead_valid);
      in_body  = !is_lead && (body_idx < head.body_count);
      last_idx = bcpe_pkg::TOT_W'(head.body_count) + bcpe_pkg::TOT_W'(head.lead_valid) +
                 bcpe_pkg::TOT_W'(head.status_only) - 1'b1;
      is_last  = bcpe_pkg::TOT_W'(idx_ff) == last_idx;

      item.out_byte    = is_lead ? head.lead_byte :
                         in_body ? head.body[body_idx[bcpe_pkg::IDX_W-1:0]] : 8'd0;
      item.has_byte    = is_lead || in_body;
      item.run_end     = is_last;
      item.message_end = is_last && head.msg_end;
      item.status      = (!is_lead && !in_body) ? head.status : bcpe_pkg::STATUS_OK;

      // output register loads whenever a command waits and the register is empty or being drained
      advance      = head_valid && (!rsp_valid_ff || rsp_tready);
      pop          = advance && is_last;
      idx_in       = advance ? (is_last ? '0 : idx_ff + 1'b1) : idx_ff;
      rsp_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
      rsp_in       = advance ? item : rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_word   = rsp_ff;

   `BCPE_ASSERT(a_status_word_ends_msg, clock, reset, rsp_valid_ff && !rsp_ff.has_byte |-> rsp_ff.message_end)
   `BCPE_ASSERT(a_msg_end_ends_run, clock, reset, rsp_valid_ff && rsp_ff.message_end |-> rsp_ff.run_end)
   `BCPE_ASSERT(a_status_no_byte, clock, reset, rsp_valid_ff && (rsp_ff.status != bcpe_pkg::STATUS_OK) |-> !rsp_ff.has_byte)
   `BCPE_ASSERT(a_idx_in_range, clock, reset, head_valid |-> (bcpe_pkg::TOT_W'(idx_ff) <= last_idx))

endmodule

// ----- tb/sv/padding_stream_checker.sv -----
`timescale 1ns / 1ps

// Watches the byte channels and the register port of the padding engine,
// predicts every output word and compares it with what the block sends.
module padding_stream_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [127:0]                    req_tdata,
   input  logic                            req_tlast,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [15:0]                     rsp_tdata,
   input  logic [1:0]                      rsp_tuser,
   input  logic                            rsp_tlast,
   input  logic                            csr_wr_en,
   input  logic [bcpe_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bcpe_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                              fail_count,
   output int                              pending_count,
   output int                              checked_count
);

   // shadow of the registers and of the engine state
   logic [1:0] scheme_q;
   logic       strip_q;
   int         pad_pos;
   logic [7:0] held_bytes [bcpe_pkg::BLOCK_BYTES];
   int         held_cnt;

   bcpe_pkg::rsp_type expected_words [$];
   int                fails;
   int                checked;

   function automatic bcpe_pkg::rsp_type make_word(input logic [7:0] b, input logic has,
                                                   input logic [1:0] st);
      bcpe_pkg::rsp_type w;
      w = '0;
      w.out_byte = b;
      w.has_byte = has;
      w.status   = st;
      return w;
   endfunction

   // works out the words that one accepted input byte causes
   task automatic predict_padding(input logic [7:0] din, input logic fin,
                                  input logic [63:0] rlo, input logic [55:0] rhi);
      bcpe_pkg::rsp_type run_q [$];
      bcpe_pkg::rsp_type w;
      logic [1:0] sch;
      logic [1:0] st;
      logic [7:0] fill;
      int         plen;
      int         n;
      int         i;
      int         j;
      sch = (scheme_q == bcpe_pkg::SCHEME_RESERVED) ? bcpe_pkg::SCHEME_PKCS7 : scheme_q;
      if (!strip_q) begin
         // pad: pass the byte, then append the pad on the last one
         run_q = {run_q, make_word(din, 1'b1, bcpe_pkg::STATUS_OK)};
         pad_pos = (pad_pos + 1) % bcpe_pkg::BLOCK_BYTES;
         if (fin) begin
            plen = bcpe_pkg::BLOCK_BYTES - pad_pos;
            for (i = 0; i < plen - 1; i++) begin
               if (sch == bcpe_pkg::SCHEME_ISO10126) begin
                  j = i % bcpe_pkg::RAND_BYTES;
                  fill = (j < 8) ? rlo[8*j +: 8] : rhi[8*(j-8) +: 8];
               end else if (sch == bcpe_pkg::SCHEME_X923) begin
                  fill = 8'h00;
               end else begin
                  fill = 8'(plen);
               end
               run_q = {run_q, make_word(fill, 1'b1, bcpe_pkg::STATUS_OK)};
            end
            w = make_word(8'(plen), 1'b1, bcpe_pkg::STATUS_OK);
            w.message_end = 1'b1;
            run_q = {run_q, w};
            pad_pos = 0;
         end
      end else begin
         // strip: the oldest held byte leaves once the window is full
         if (held_cnt == bcpe_pkg::BLOCK_BYTES) begin
            run_q = {run_q, make_word(held_bytes[0], 1'b1, bcpe_pkg::STATUS_OK)};
            for (i = 0; i < bcpe_pkg::BLOCK_BYTES - 1; i++)
               held_bytes[i] = held_bytes[i+1];
            held_cnt = bcpe_pkg::BLOCK_BYTES - 1;
         end
         held_bytes[held_cnt] = din;
         held_cnt++;
         if (fin) begin
            n = held_cnt;
            plen = held_bytes[n-1];
            st = bcpe_pkg::STATUS_OK;
            if (plen == 0 || plen > bcpe_pkg::BLOCK_BYTES || plen > n) begin
               st = bcpe_pkg::STATUS_BAD_LENGTH;
            end else if (sch == bcpe_pkg::SCHEME_PKCS7) begin
               for (i = n - plen; i < n; i++)
                  if (held_bytes[i] != plen) st = bcpe_pkg::STATUS_BAD_CONTENT;
            end else if (sch == bcpe_pkg::SCHEME_X923) begin
               for (i = n - plen; i < n - 1; i++)
                  if (held_bytes[i] != 8'h00) st = bcpe_pkg::STATUS_BAD_CONTENT;
            end
            if (st == bcpe_pkg::STATUS_OK && n - plen > 0) begin
               for (i = 0; i < n - plen; i++)
                  run_q = {run_q, make_word(held_bytes[i], 1'b1, bcpe_pkg::STATUS_OK)};
            end else begin
               run_q = {run_q, make_word(8'h00, 1'b0, st)};
            end
            run_q[run_q.size() - 1].message_end = 1'b1;
            held_cnt = 0;
         end
      end
      // last word of this input closes the run
      if (run_q.size() > 0)
         run_q[run_q.size() - 1].run_end = 1'b1;
      foreach (run_q[k])
         expected_words = {expected_words, run_q[k]};
   endtask

   always @(posedge clock) begin
      bcpe_pkg::rsp_type got;
      bcpe_pkg::rsp_type want;
      if (reset) begin
         scheme_q = bcpe_pkg::SCHEME_PKCS7;
         strip_q  = 1'b0;
         pad_pos  = 0;
         held_cnt = 0;
         expected_words.delete();
         fails    = 0;
         checked  = 0;
      end else begin
         // compare before predicting: a word never answers the byte of the same edge
         if (rsp_tvalid && rsp_tready) begin
            got = '0;
            got.out_byte    = rsp_tdata[7:0];
            got.status      = rsp_tdata[9:8];
            got.has_byte    = rsp_tuser[0];
            got.run_end     = rsp_tuser[1];
            got.message_end = rsp_tlast;
            if (expected_words.size() == 0) begin
               fails++;
               $display("%0t: expected no word, got byte=%h has=%b run_end=%b msg_end=%b st=%0d",
                        $time, got.out_byte, got.has_byte, got.run_end,
                        got.message_end, got.status);
            end else begin
               want = expected_words.pop_front();
               checked++;
               if (got.out_byte != want.out_byte || got.has_byte != want.has_byte ||
                   got.run_end != want.run_end || got.message_end != want.message_end ||
                   got.status != want.status) begin
                  fails++;
                  $display("%0t: word %0d expected byte=%h has=%b run_end=%b msg_end=%b st=%0d",
                           $time, checked, want.out_byte, want.has_byte, want.run_end,
                           want.message_end, want.status);
                  $display("%0t: word %0d got      byte=%h has=%b run_end=%b msg_end=%b st=%0d",
                           $time, checked, got.out_byte, got.has_byte,
                           got.run_end, got.message_end, got.status);
               end
            end
         end
         if (req_tvalid && req_tready)
            predict_padding(req_tdata[7:0], req_tlast, req_tdata[71:8], req_tdata[127:72]);
         // register writes take effect for later bytes
         if (csr_wr_en) begin
            if (csr_index == bcpe_pkg::REG_PAD_SCHEME)
               scheme_q = csr_wdata[1:0];
            else if (csr_index == bcpe_pkg::REG_STRIP_DIRECTION)
               strip_q = csr_wdata[0];
         end
      end
      fail_count    <= fails;
      pending_count <= expected_words.size();
      checked_count <= checked;
   end

endmodule

// ----- tb/sv/tb_block_cipher_padding_engine_unit.sv -----
`timescale 1ns / 1ps

module tb_block_cipher_padding_engine_unit;

   localparam int  RESET_CYCLES = 7;
   localparam int  SETTLE       = 24;
   localparam int  HOLD_LEN     = 300;
   localparam int  PHASE_WORDS  = 80;
   localparam longint CYCLE_LIMIT = 400000;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [127:0]                    req_tdata = '0;
   logic                            req_tlast = 1'b0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [15:0]                     rsp_tdata;
   logic [1:0]                      rsp_tuser;
   logic                            rsp_tlast;
   logic                            csr_wr_en = 1'b0;
   logic [bcpe_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [bcpe_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   int     fail_count;
   int     pending_count;
   int     checked_count;
   int     tx_idle_pct = 0;
   int     rx_idle_pct = 0;
   int     words_sent = 0;
   int     messages_sent = 0;
   int     hold_seq = 0;
   int     hold_ack = 0;
   int     hold_left = 0;
   longint cycle_count = 0;
   logic [1:0] cur_scheme = bcpe_pkg::SCHEME_PKCS7;
   logic       cur_strip = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   block_cipher_padding_engine_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   padding_stream_checker u_chk (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tlast     (req_tlast),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .rsp_tlast     (rsp_tlast),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .checked_count (checked_count)
   );

   // receiver: random stalls, or a long counted hold when asked for
   always @(posedge clock) begin
      if (hold_seq != hold_ack) begin
         hold_ack   <= hold_seq;
         hold_left  <= HOLD_LEN;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // one input word, with an optional sender gap in front of it
   task automatic send_word(input logic [7:0] b, input logic fin,
                            input logic [63:0] lo, input logic [55:0] hi);
      if ($urandom_range(0, 99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {hi, lo, b};
      req_tlast  <= fin;
      do @(posedge clock); while (!req_tready);
      words_sent++;
      if (fin) messages_sent++;
   endtask

   // a run of bytes; fresh random filler per word unless fixed filler is given
   task automatic send_run(input logic [7:0] msg [$], input logic fin, input logic fixed_fill,
                           input logic [63:0] lo, input logic [55:0] hi);
      logic [63:0] flo;
      logic [55:0] fhi;
      foreach (msg[i]) begin
         flo = fixed_fill ? lo : {$urandom, $urandom};
         fhi = fixed_fill ? hi : 56'({$urandom, $urandom});
         send_word(msg[i], fin && (i == msg.size() - 1), flo, fhi);
      end
   endtask

   // wait until every expected word has come, then let the block settle
   task automatic drain_quiet();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   // both registers, back to back, only while the block is idle
   task automatic set_config(input logic [1:0] sch, input logic strip);
      drain_quiet();
      csr_wr_en <= 1'b1;
      csr_index <= bcpe_pkg::REG_PAD_SCHEME;
      csr_wdata <= sch;
      @(posedge clock);
      csr_index <= bcpe_pkg::REG_STRIP_DIRECTION;
      csr_wdata <= {1'b0, strip};
      @(posedge clock);
      csr_wr_en  <= 1'b0;
      cur_scheme = sch;
      cur_strip  = strip;
   endtask

   // pad direction: random message, lengths biased toward whole blocks
   task automatic send_pad_message(input int len_max);
      logic [7:0] msg [$];
      int         len;
      int         pick;
      pick = $urandom_range(0, 9);
      len = (pick == 0) ? bcpe_pkg::BLOCK_BYTES :
            (pick == 1) ? 2 * bcpe_pkg::BLOCK_BYTES : $urandom_range(1, len_max);
      repeat (len) msg = {msg, 8'($urandom)};
      // now and then leave the message open
      send_run(msg, $urandom_range(0, 9) != 0, 1'b0, '0, '0);
   endtask

   // strip direction: mostly well-formed padded messages, some damaged, some noise
   task automatic send_strip_message();
      logic [7:0] msg [$];
      int         body_len;
      int         plen;
      int         pick;
      int         idx;
      pick = $urandom_range(0, 11);
      if (pick < 2) begin
         repeat ($urandom_range(1, 20)) msg = {msg, 8'($urandom)};
         msg[msg.size() - 1] = 8'($urandom_range(0, 20));
      end else begin
         body_len = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 24);
         plen = bcpe_pkg::BLOCK_BYTES - (body_len % bcpe_pkg::BLOCK_BYTES);
         repeat (body_len) msg = {msg, 8'($urandom)};
         repeat (plen - 1) begin
            if (cur_scheme == bcpe_pkg::SCHEME_ISO10126) msg = {msg, 8'($urandom)};
            else if (cur_scheme == bcpe_pkg::SCHEME_X923) msg = {msg, 8'h00};
            else msg = {msg, 8'(plen)};
         end
         msg = {msg, 8'(plen)};
         // damage a pad byte in a few of them
         if (pick < 5) begin
            idx = msg.size() - 1 - $urandom_range(0, plen - 1);
            msg[idx] = msg[idx] ^ (8'h01 << $urandom_range(0, 7));
         end
      end
      send_run(msg, 1'b1, 1'b0, '0, '0);
   endtask

   task automatic random_phase(input int tx_pct, input int rx_pct, input logic with_hold);
      int target;
      target = words_sent + PHASE_WORDS;
      drain_quiet();
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      // long receiver hold while the sender keeps offering a pad message of up to 48 bytes
      if (with_hold) begin
         set_config(bcpe_pkg::SCHEME_PKCS7, 1'b0);
         hold_seq <= hold_seq + 1;
         send_pad_message(48);
         send_run({8'h5A}, 1'b1, 1'b0, '0, '0);
      end
      while (words_sent < target) begin
         if ($urandom_range(0, 3) == 0)
            set_config(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
         if (cur_strip) send_strip_message();
         else send_pad_message(24);
      end
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: pad direction, each scheme and filler extremes
      set_config(bcpe_pkg::SCHEME_PKCS7, 1'b0);
      send_run({8'hFF}, 1'b1, 1'b1, '0, '0);
      set_config(bcpe_pkg::SCHEME_ISO10126, 1'b0);
      send_run({8'h00}, 1'b1, 1'b1, '1, '1);
      send_run({8'h3C}, 1'b1, 1'b1, '0, '0);
      set_config(bcpe_pkg::SCHEME_X923, 1'b0);
      send_run({8'h80, 8'h7F}, 1'b1, 1'b1, '0, '0);
      set_config(bcpe_pkg::SCHEME_RESERVED, 1'b0);
      send_run({8'h55}, 1'b1, 1'b1, '0, '0);
      // open a pad message, strip a few messages in between, finish it with another scheme
      set_config(bcpe_pkg::SCHEME_PKCS7, 1'b0);
      send_run({8'h01, 8'h02}, 1'b0, 1'b1, '0, '0);
      set_config(bcpe_pkg::SCHEME_PKCS7, 1'b1);
      send_run({8'hAA, 8'h01}, 1'b1, 1'b1, '0, '0);
      // empty after stripping, zero length, length beyond the message, bad pad byte
      send_run({8'h01}, 1'b1, 1'b1, '0, '0);
      send_run({8'h00}, 1'b1, 1'b1, '0, '0);
      send_run({8'h05, 8'h03}, 1'b1, 1'b1, '0, '0);
      send_run({8'h07, 8'h03, 8'h02}, 1'b1, 1'b1, '0, '0);
      set_config(bcpe_pkg::SCHEME_X923, 1'b1);
      send_run({8'h41, 8'h00, 8'h02}, 1'b1, 1'b1, '0, '0);
      send_run({8'h00, 8'h05, 8'h02}, 1'b1, 1'b1, '0, '0);
      // length above the block size
      send_run({8'hFF}, 1'b1, 1'b1, '0, '0);
      set_config(bcpe_pkg::SCHEME_ISO10126, 1'b1);
      send_run({8'h12, 8'h99, 8'h02}, 1'b1, 1'b1, '0, '0);
      set_config(bcpe_pkg::SCHEME_X923, 1'b0);
      send_run({8'h03}, 1'b1, 1'b1, '1, '1);

      // random traffic under three idling mixes
      random_phase(31, 48, 1'b0);
      random_phase(48, 31, 1'b0);
      random_phase(0, 0, 1'b1);

      drain_quiet();
      $display("Sent %0d bytes in %0d messages through pad and strip with all scheme codes,",
               words_sent, messages_sent);
      $display("valid, damaged and noise pads, a long output hold; %0d output words checked.",
               checked_count);
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("%0d failures", fail_count);
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
